### design/xsrg_pkg.sv
// Shared types, constants and mixing functions for the xorshift1024* range generator.
// No dependencies.
package xsrg_pkg;

    localparam int WORD_CNT = 16;
    localparam int PTR_W    = 4;

    localparam logic [63:0] MUL64   = 64'd2685821657736338717;
    localparam logic [63:0] MUL1024 = 64'd1181783497276652981;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // request kinds carried on s_axis_tuser
    localparam logic REQ_RESEED = 1'b0;
    localparam logic REQ_DRAW   = 1'b1;

    typedef logic [63:0] word_t;
    typedef logic [PTR_W-1:0] ptr_t;

    // xorshift64 state update (shifts 12, 25, 27)
    function automatic word_t xs64(input word_t s);
        word_t x;
        x = s;
        x = x ^ (x >> 12);
        x = x ^ (x << 25);
        x = x ^ (x >> 27);
        return x;
    endfunction

    // xorshift1024 word mix (shifts 31, 11, 30)
    function automatic word_t xs1024(input word_t a, input word_t b);
        word_t bb;
        word_t aa;
        bb = b ^ (b << 31);
        bb = bb ^ (bb >> 11);
        aa = a ^ (a >> 30);
        return aa ^ bb;
    endfunction

endpackage

### design/xsrg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module xsrg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/xsrg_mul.sv
// 64x64 multiplier, low 64 bits of the product, one 32x32 partial product per cycle.
// Depends on xsrg_pkg.
module xsrg_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  xsrg_pkg::word_t a,
    input  xsrg_pkg::word_t b,
    output logic          done,
    output xsrg_pkg::word_t prod
);
    import xsrg_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LL   = 3'd1;
    localparam logic [2:0] PH_LH   = 3'd2;
    localparam logic [2:0] PH_HL   = 3'd3;
    localparam logic [2:0] PH_SUM  = 3'd4;

    logic [2:0]  ph_reg, ph_next;
    word_t       a_reg, b_reg;
    logic [63:0] p0_reg;
    logic [31:0] p1_reg, p2_reg;
    logic [31:0] op_x, op_y;
    logic [63:0] pp;
    logic        done_reg;
    word_t       prod_reg;

    always_comb
    begin
        unique case (ph_reg)
            PH_LH:   begin op_x = a_reg[31:0];  op_y = b_reg[63:32]; end
            PH_HL:   begin op_x = a_reg[63:32]; op_y = b_reg[31:0];  end
            default: begin op_x = a_reg[31:0];  op_y = b_reg[31:0];  end
        endcase
        pp = op_x * op_y;
    end

    always_comb
    begin
        unique case (ph_reg)
            PH_IDLE: ph_next = start ? PH_LL : PH_IDLE;
            PH_LL:   ph_next = PH_LH;
            PH_LH:   ph_next = PH_HL;
            PH_HL:   ph_next = PH_SUM;
            default: ph_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= (ph_reg == PH_SUM);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ph_reg == PH_IDLE && start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (ph_reg == PH_LL) p0_reg <= pp;
        if (ph_reg == PH_LH) p1_reg <= pp[31:0];
        if (ph_reg == PH_HL) p2_reg <= pp[31:0];
        if (ph_reg == PH_SUM)
        begin
            prod_reg <= p0_reg + {p1_reg + p2_reg, 32'd0};
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

### design/xsrg_div.sv
// Restoring 64-bit divider, one quotient bit per cycle; only the remainder is kept.
// Depends on xsrg_pkg.
module xsrg_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  xsrg_pkg::word_t dividend,
    input  xsrg_pkg::word_t divisor,
    output logic            done,
    output xsrg_pkg::word_t rem
);
    import xsrg_pkg::*;

    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    word_t       dvd_reg, dsr_reg, rem_reg;
    logic [64:0] trial;
    logic [64:0] diff;

    assign trial = {rem_reg, dvd_reg[63]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            rem_reg <= diff[64] ? trial[63:0] : diff[63:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### design/xorshift1024_star_range_generator_top.sv
// Top level of the xorshift1024* range generator: sequencer, word memory,
// multiplier and divider. Depends on xsrg_pkg, xsrg_ram, xsrg_mul, xsrg_div.
//
// Usage:
//   Input items arrive on s_axis_*. tuser is req_type (0 reseed, 1 draw).
//   tdata holds seed_value, range_low, range_high from bit 0 up.
//   Every input item yields exactly one result item on m_axis_*:
//   tdata = drawn_value, tuser = range_error.
//   One item is worked at a time; s_axis_tready is high only while idle.
//   Work per item, from acceptance to the output register:
//     reseed: for each of the 16 words, a multiply of the stepped seed, then a write.
//     draw, inverted bounds: straight to the result stage, with range_error set.
//     draw, full span: one generator step, then the load of the output register.
//     draw, other spans: the rejection limit (64-bit bit-serial divider), then
//             generator steps (two memory reads, mix and write, multiply) until
//             a value is below the limit, then the final remainder, then the
//             load of the output register.
//   The generator step reads its two words one after the other through the
//   single memory read port.
//   The result sits in an output register; the next item is accepted while it
//   waits. If the receiver stalls, the block holds a finished result until
//   the register is free.
//   Reset: all sixteen words read as zero (per-word valid bits are cleared),
//   the word pointer is zero and no result is pending.
module xorshift1024_star_range_generator_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // seed_value[63:0], range_low[127:64], range_high[191:128]
    input  logic         s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // drawn_value
    output logic         m_axis_tuser   // range_error
);
    import xsrg_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SEED_GO = 4'd1;
    localparam logic [3:0] ST_SEED_W  = 4'd2;
    localparam logic [3:0] ST_DLIM_GO = 4'd3;
    localparam logic [3:0] ST_DLIM_W  = 4'd4;
    localparam logic [3:0] ST_RD_A    = 4'd5;
    localparam logic [3:0] ST_RD_B    = 4'd6;
    localparam logic [3:0] ST_STEP    = 4'd7;
    localparam logic [3:0] ST_STEP_W  = 4'd8;
    localparam logic [3:0] ST_DRES_GO = 4'd9;
    localparam logic [3:0] ST_DRES_W  = 4'd10;
    localparam logic [3:0] ST_FIN     = 4'd11;

    logic [3:0]           st_reg, st_next;
    ptr_t                 ptr_reg, cnt_reg;
    logic [WORD_CNT-1:0]  valid_reg;
    word_t                s_reg, lo_reg, n_reg, limit_reg, a_reg, raw_reg;
    logic                 full_reg;
    word_t                res_data_reg;
    logic                 res_err_reg;
    logic                 out_valid_reg;
    word_t                out_data_reg;
    logic                 out_err_reg;

    word_t in_seed, in_lo, in_hi, span;
    ptr_t  ptr_nx;
    word_t rdata, word_a, word_b, mixed;
    logic  we;
    ptr_t  waddr, raddr;
    word_t wdata;

    logic  mul_start, mul_done;
    word_t mul_a, mul_b, mul_prod;
    logic  div_start, div_done;
    word_t div_dvd, div_rem;

    logic  in_acc, out_free;

    assign in_seed = s_axis_tdata[63:0];
    assign in_lo   = s_axis_tdata[127:64];
    assign in_hi   = s_axis_tdata[191:128];
    assign span    = in_hi - in_lo;
    assign ptr_nx  = ptr_reg + 4'd1;

    assign s_axis_tready = (st_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // unwritten words read as zero
    assign word_a = valid_reg[ptr_reg] ? rdata : '0;
    assign word_b = valid_reg[ptr_nx] ? rdata : '0;
    assign mixed  = xs1024(a_reg, word_b);

    always_comb
    begin
        raddr = (st_reg == ST_RD_B) ? ptr_nx : ptr_reg;
        we    = 1'b0;
        waddr = ptr_nx;
        wdata = mixed;
        if (st_reg == ST_SEED_W && mul_done)
        begin
            we    = 1'b1;
            waddr = cnt_reg;
            wdata = mul_prod;
        end
        else if (st_reg == ST_STEP)
        begin
            we = 1'b1;
        end
    end

    assign mul_start = (st_reg == ST_SEED_GO) || (st_reg == ST_STEP);
    assign mul_a     = (st_reg == ST_STEP) ? mixed : s_reg;
    assign mul_b     = (st_reg == ST_STEP) ? MUL1024 : MUL64;
    assign div_start = (st_reg == ST_DLIM_GO) || (st_reg == ST_DRES_GO);
    assign div_dvd   = (st_reg == ST_DLIM_GO) ? ALL_ONES : raw_reg;

    xsrg_ram #(
        .WIDTH(64),
        .DEPTH(WORD_CNT)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    xsrg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    xsrg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (n_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    // sequencer
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tuser == REQ_RESEED) st_next = ST_SEED_GO;
                    else if (in_lo > in_hi)         st_next = ST_FIN;
                    else if (span == ALL_ONES)      st_next = ST_RD_A;
                    else                            st_next = ST_DLIM_GO;
                end
            end
            ST_SEED_GO: st_next = ST_SEED_W;
            ST_SEED_W:
            begin
                if (mul_done)
                begin
                    st_next = (cnt_reg == ptr_t'(WORD_CNT - 1)) ? ST_FIN : ST_SEED_GO;
                end
            end
            ST_DLIM_GO: st_next = ST_DLIM_W;
            ST_DLIM_W:  st_next = div_done ? ST_RD_A : ST_DLIM_W;
            ST_RD_A:    st_next = ST_RD_B;
            ST_RD_B:    st_next = ST_STEP;
            ST_STEP:    st_next = ST_STEP_W;
            ST_STEP_W:
            begin
                if (mul_done)
                begin
                    if (full_reg)                   st_next = ST_FIN;
                    else if (mul_prod >= limit_reg) st_next = ST_RD_A;
                    else                            st_next = ST_DRES_GO;
                end
            end
            ST_DRES_GO: st_next = ST_DRES_W;
            ST_DRES_W:  st_next = div_done ? ST_FIN : ST_DRES_W;
            ST_FIN:     st_next = out_free ? ST_IDLE : ST_FIN;
            default:    st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (in_acc && s_axis_tuser == REQ_RESEED)
            begin
                cnt_reg <= '0;
            end
            if (st_reg == ST_SEED_W && mul_done)
            begin
                valid_reg[cnt_reg] <= 1'b1;
                cnt_reg            <= cnt_reg + 4'd1;
                if (cnt_reg == ptr_t'(WORD_CNT - 1))
                begin
                    ptr_reg <= '0;
                end
            end
            if (st_reg == ST_STEP)
            begin
                valid_reg[ptr_nx] <= 1'b1;
                ptr_reg           <= ptr_nx;
            end
            if (st_reg == ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s_reg        <= xs64(in_seed);
            lo_reg       <= in_lo;
            n_reg        <= span + 64'd1;
            full_reg     <= (span == ALL_ONES);
            res_data_reg <= '0;
            res_err_reg  <= (s_axis_tuser != REQ_RESEED) && (in_lo > in_hi);
        end
        if (st_reg == ST_SEED_W && mul_done)
        begin
            s_reg <= xs64(s_reg);
        end
        if (st_reg == ST_DLIM_W && div_done)
        begin
            limit_reg <= ~div_rem;
        end
        if (st_reg == ST_RD_B)
        begin
            a_reg <= word_a;
        end
        if (st_reg == ST_STEP_W && mul_done)
        begin
            raw_reg      <= mul_prod;
            res_data_reg <= mul_prod;
        end
        if (st_reg == ST_DRES_W && div_done)
        begin
            res_data_reg <= div_rem + lo_reg;
        end
        if (st_reg == ST_FIN && out_free)
        begin
            out_data_reg <= res_data_reg;
            out_err_reg  <= res_err_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_err_reg;

endmodule

### design/xsrg_chk.sv
// Port-level checker for the xorshift1024* range generator and its bind.
// Depends on xorshift1024_star_range_generator_top.
module xsrg_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic         m_axis_tuser
);

    // an error item never carries a value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
        else $error("error item with nonzero data");

    // one item at a time: input closes right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready while busy");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind xorshift1024_star_range_generator_top xsrg_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/testbench.sv
// Testbench for the xorshift1024* range generator: directed and random reseed/draw items,
// a built-in generator/range predictor, and a field-by-field result checker.
// Depends on xsrg_pkg and xorshift1024_star_range_generator_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import xsrg_pkg::*;

    localparam logic [63:0] SEED_MUL = 64'd2685821657736338717;
    localparam logic [63:0] GEN_MUL  = 64'd1181783497276652981;
    localparam logic [63:0] MAX_U64  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        kind;
        logic [63:0] seed;
        logic [63:0] lo;
        logic [63:0] hi;
    } req_item_t;

    typedef struct packed {
        logic [63:0] value;
        logic        err;
    } draw_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;   // seed_value, range_low, range_high
    logic         s_axis_tuser;   // req_type
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;   // drawn_value
    logic         m_axis_tuser;   // range_error

    xorshift1024_star_range_generator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predictor state: generator words and rotating pointer
    logic [63:0] gen_state [16];
    logic [3:0]  gen_ptr;

    req_item_t    pending_items[$];
    draw_result_t expected_draws[$];
    int           error_count;
    bit           calm_phase;     // no idling in the tail of the run
    bit           hold_sink;      // long receiver stall request
    bit           hold_source;    // sender waits for drain
    bit           src_taken;      // offered item was accepted at the last rising edge

    always #10 clk = ~clk;

    function automatic logic [63:0] next_raw();
        logic [63:0] a;
        logic [63:0] b;
        a = gen_state[gen_ptr];
        gen_ptr = gen_ptr + 4'd1;
        b = gen_state[gen_ptr];
        b = b ^ (b << 31);
        b = b ^ (b >> 11);
        a = a ^ (a >> 30);
        gen_state[gen_ptr] = a ^ b;
        return (a ^ b) * GEN_MUL;
    endfunction

    // Expected result of one request; updates the predictor state
    function automatic draw_result_t predict_draw(req_item_t it);
        draw_result_t r;
        logic [63:0] s;
        logic [63:0] n;
        logic [63:0] lim;
        logic [63:0] raw;
        r = '0;
        if (it.kind == REQ_RESEED) begin
            s = it.seed;
            for (int i = 0; i < 16; i++) begin
                s = s ^ (s >> 12);
                s = s ^ (s << 25);
                s = s ^ (s >> 27);
                gen_state[i] = s * SEED_MUL;
            end
            gen_ptr = '0;
        end else if (it.lo > it.hi) begin
            r.err = 1'b1;
        end else if (it.hi - it.lo == MAX_U64) begin
            r.value = next_raw();
        end else begin
            n = it.hi - it.lo + 64'd1;
            lim = (MAX_U64 / n) * n;
            do raw = next_raw(); while (raw >= lim);
            r.value = raw % n + it.lo;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic req_item_t make_item(logic k, logic [63:0] sd, logic [63:0] l,
                                            logic [63:0] h);
        req_item_t it;
        it.kind = k;
        it.seed = sd;
        it.lo = l;
        it.hi = h;
        return it;
    endfunction

    // Some reseeds; many small spans (fast), some large, some full, a few inverted
    function automatic req_item_t random_item();
        logic [63:0] l;
        logic [63:0] h;
        int sel;
        sel = $urandom_range(0, 99);
        l = rand64();
        if (sel < 5)
            return make_item(REQ_RESEED, rand64(), rand64(), rand64());
        if (sel < 10) begin
            h = rand64();
            if (h >= l)
                return make_item(REQ_DRAW, rand64(), h + 64'd1 == 64'd0 ? l : h + 64'd1, l);
            return make_item(REQ_DRAW, rand64(), l, h);
        end
        if (sel < 14)
            return make_item(REQ_DRAW, rand64(), 64'd0, MAX_U64);
        if (sel < 60)
            h = l + 64'($urandom_range(0, 20));
        else if (sel < 80)
            h = l + 64'($urandom);
        else
            h = l + (rand64() >> $urandom_range(0, 63));
        if (h < l) h = MAX_U64;
        return make_item(REQ_DRAW, rand64(), l, h);
    endfunction

    // Driver: offer queued items at the falling edge; an offered item stays
    // until it is taken
    int src_gap;
    always @(negedge clk) begin
        if (rst_n) begin
            if (s_axis_tvalid && !src_taken) begin
                // still waiting for acceptance
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (hold_source && expected_draws.size() != 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                if (!calm_phase && $urandom_range(0, 9) == 0) begin
                    src_gap <= $urandom_range(0, 10);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_items[0].kind;
                    s_axis_tdata  <= {pending_items[0].hi, pending_items[0].lo,
                                      pending_items[0].seed};
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Predict on acceptance, seen at the rising edge; retire the offered item
    always @(posedge clk) begin
        src_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_draws.push_back(predict_draw(make_item(s_axis_tuser,
                s_axis_tdata[63:0], s_axis_tdata[127:64], s_axis_tdata[191:128])));
            void'(pending_items.pop_front());
        end
    end

    // Receiver ready: random stall bursts, plus one long hold-off
    int sink_gap;
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk) begin
        draw_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_draws.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 64'd0);
            end else begin
                want = expected_draws.pop_front();
                if (m_axis_tdata !== want.value)
                    report_mismatch("drawn_value", m_axis_tdata, want.value);
                if (m_axis_tuser !== want.err)
                    report_mismatch("range_error", 64'(m_axis_tuser), 64'(want.err));
            end
        end
    end

    task automatic wait_drain();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_draws.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        clk = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = 0;
        m_axis_tready = 0;
        error_count = 0;
        calm_phase = 0;
        hold_sink = 0;
        hold_source = 0;
        src_gap = 0;
        sink_gap = 0;
        for (int i = 0; i < 16; i++) gen_state[i] = '0;
        gen_ptr = '0;
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1;

        // Directed: zero state draws, inverted bounds, full span, extremes, reseeds
        pending_items.push_back(make_item(REQ_DRAW, '0, 64'd5, 64'd100));
        pending_items.push_back(make_item(REQ_DRAW, '0, 64'd0, MAX_U64));
        pending_items.push_back(make_item(REQ_DRAW, MAX_U64, 64'd7, 64'd6));
        pending_items.push_back(make_item(REQ_RESEED, 64'd0, '0, '0));
        pending_items.push_back(make_item(REQ_DRAW, '0, MAX_U64, MAX_U64));
        pending_items.push_back(make_item(REQ_RESEED, MAX_U64, MAX_U64, MAX_U64));
        pending_items.push_back(make_item(REQ_DRAW, '0, 64'd0, MAX_U64));
        pending_items.push_back(make_item(REQ_DRAW, '0, 64'd0, 64'd0));
        pending_items.push_back(make_item(REQ_DRAW, '0, 64'd0, 64'd1));
        pending_items.push_back(make_item(REQ_DRAW, '0, MAX_U64, 64'd0));
        pending_items.push_back(make_item(REQ_DRAW, '0, 64'd1, MAX_U64));
        pending_items.push_back(make_item(REQ_DRAW, '0, 64'd0, MAX_U64 - 1));
        pending_items.push_back(make_item(REQ_DRAW, '0, 64'd0, 64'h8000_0000_0000_0000));
        pending_items.push_back(make_item(REQ_DRAW, '0, 64'd3, 64'h7FFF_FFFF_FFFF_FFFF));
        pending_items.push_back(make_item(REQ_RESEED, 64'h0123_4567_89AB_CDEF, '0, '0));
        pending_items.push_back(make_item(REQ_DRAW, MAX_U64, 64'd10, 64'd12));
        pending_items.push_back(make_item(REQ_DRAW, '0, 64'd1000, 64'd1000));
        wait_drain();

        // Long receiver hold-off while the sender keeps offering
        hold_sink = 1;
        for (int i = 0; i < 8; i++) pending_items.push_back(random_item());
        repeat (400) @(posedge clk);
        hold_sink = 0;
        wait_drain();

        for (int i = 0; i < 1780; i++) begin
            if (i == 600) hold_source = 1;
            if (i == 620) hold_source = 0;
            if (i == 1500) calm_phase = 1;
            while (pending_items.size() > 4) @(posedge clk);
            pending_items.push_back(random_item());
        end
        wait_drain();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #60ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
